[hdl/ipru_pkg.sv]
// Shared types and codes for the integer pixel replication upscaler.
`timescale 1ns / 1ps

package ipru_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // input word kinds, carried on in_tuser
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam int PX_W   = 24;
  localparam int CFG_W  = 16;
  localparam int SCL_W  = 5;
  localparam int WID_W  = 11;
  localparam int HGT_W  = 16;
  localparam int ODAT_W = 32;

  typedef enum logic [1:0] {
    JOB_PIX,
    JOB_TICK,
    JOB_DROP
  } job_kind_t;

endpackage

[hdl/integer_pixel_replication_upscaler_top.sv]
// Integer pixel replication upscaler: line store, replay counters and output stage.
`timescale 1ns / 1ps

// Nearest-neighbor integer upscaler for RGB pixel streams.
// Input words (in_*): in_tuser = 0 carries a source pixel in raster order, in_tuser = 1
// is a tick that asks for one replayed pixel of the stored row. Each source pixel is
// written to the line store and sent scale_factor times; once a source row is complete,
// ticks replay it scale_factor-1 more times. A pixel that arrives during a replay is
// discarded and answered with one word marked dropped. A tick with nothing to replay
// gives no output.
// Output words (out_*) are taken when out_tvalid and out_tready are high; out_tlast marks
// the final word caused by an input word.
// An accepted input word is registered in the job stage and its words then move to the
// output register. A pixel gives scale_factor output words; ticks and dropped pixels
// give one word each; a tick stream runs at one word per cycle while out_tready is high.
// The line store is a single-port-write, single-port-read RAM with a registered read;
// a tick reads it at accept; the data is used as the tick job enters the output register.
// Writing scale_factor starts a bit-serial restoring-division recomputation of
// the replay column, during which in_tready is low.
// Reset (rst_n low, synchronous) sets factor, width and height to 1 and clears all
// counters and both word stages; store contents stay undefined until written.
// When out_tready is low, the output word holds and in_tready drops once the pending
// job cannot move on.

module integer_pixel_replication_upscaler_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_FACTOR = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_addr,
  input  logic [ipru_pkg::CFG_W-1:0] cfg_wdata,
  // input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [ipru_pkg::PX_W-1:0]  in_tdata,   // blue[7:0], green[15:8], red[23:16]
  input  logic                       in_tuser,   // func
  // output stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // blue[7:0], green[15:8], red[23:16], pad_after[25:24], row_end[26], image_end[27]
  output logic [ipru_pkg::ODAT_W-1:0] out_tdata,
  output logic                       out_tuser,  // dropped
  output logic                       out_tlast   // last_of_run
);

  import ipru_pkg::*;

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int POS_W  = (MAX_WIDTH * MAX_FACTOR > 1) ? $clog2(MAX_WIDTH * MAX_FACTOR) : 1;
  localparam int WF_W   = $clog2(MAX_WIDTH * MAX_FACTOR + 1);
  localparam int FW     = $clog2(MAX_FACTOR + 1);
  localparam int SUB_W  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int DCNT_W = $clog2(POS_W + 1);

  // configuration registers
  logic [SCL_W-1:0] scale_r;
  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;

  // effective settings
  logic [FW-1:0]    eff_f;
  logic [WID_W-1:0] eff_w;
  logic [HGT_W-1:0] eff_h;
  logic [WF_W-1:0]  wf;
  logic [1:0]       row_pad;

  // sequencing state
  logic [COL_W-1:0] col_r, col_nxt;
  logic [HGT_W-1:0] row_r, row_nxt;
  logic [SUB_W-1:0] reps_r, reps_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] idx_r, idx_nxt;
  logic [SUB_W-1:0] sub_r, sub_nxt;

  // replay column recomputation after a factor change
  logic              div_busy_r;
  logic [DCNT_W-1:0] div_cnt_r;
  logic [POS_W-1:0]  div_q_r;
  logic [FW-1:0]     div_rem_r;
  logic [FW:0]       div_trial;
  logic              div_ge;
  logic [FW-1:0]     div_rem_nxt;
  logic [POS_W-1:0]  div_q_nxt;
  logic              div_start;

  // line store
  logic [PX_W-1:0]  store_mem [MAX_WIDTH];
  logic [PX_W-1:0]  mem_q_r;
  logic             wr_en, rd_en;
  logic [COL_W-1:0] wr_addr, rd_addr;

  // job stage
  logic             job_valid_r, job_valid_nxt;
  job_kind_t        job_kind_r, job_kind_nxt;
  logic [PX_W-1:0]  job_px_r, job_px_nxt;
  logic [FW-1:0]    job_left_r, job_left_nxt;
  logic             job_re_r, job_re_nxt;
  logic             job_ie_r, job_ie_nxt;
  logic [1:0]       job_pad_r, job_pad_nxt;
  logic             job_last;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [PX_W-1:0]  out_px_r, out_px_nxt;
  logic [1:0]       out_pad_r, out_pad_nxt;
  logic             out_re_r, out_re_nxt;
  logic             out_ie_r, out_ie_nxt;
  logic             out_drop_r, out_drop_nxt;
  logic             out_last_r, out_last_nxt;

  logic in_acc, out_load;
  logic row_wrap, col_wrap, pos_wrap, sub_wrap;
  logic [HGT_W-1:0] row_inc;

  // ---------------------------------------------------------------- settings
  always_comb begin
    if (scale_r == '0) begin
      eff_f = FW'(1);
    end else if (32'(scale_r) > MAX_FACTOR) begin
      eff_f = FW'(MAX_FACTOR);
    end else begin
      eff_f = FW'(scale_r);
    end
    if (width_r == '0) begin
      eff_w = WID_W'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = width_r;
    end
    eff_h = (height_r == '0) ? HGT_W'(1) : height_r;
  end

  assign wf      = WF_W'(eff_w * eff_f);
  // (4 - 3*W mod 4) mod 4 reduces to W mod 4
  assign row_pad = wf[1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCL_W'(1);
      width_r  <= WID_W'(1);
      height_r <= HGT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SCALE:  scale_r  <= cfg_wdata[SCL_W-1:0];
        REG_WIDTH:  width_r  <= cfg_wdata[WID_W-1:0];
        REG_HEIGHT: height_r <= cfg_wdata[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  assign job_last  = (job_left_r == FW'(1));
  assign out_load  = job_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !div_busy_r && (!job_valid_r || (out_load && job_last));
  assign in_acc    = in_tvalid && in_tready;
  assign div_start = cfg_we && (cfg_addr == REG_SCALE);

  assign row_wrap = (32'(row_r) + 32'd1) >= 32'(eff_h);
  assign row_inc  = row_wrap ? '0 : row_r + HGT_W'(1);
  assign col_wrap = (32'(col_r) + 32'd1) >= 32'(eff_w);
  assign pos_wrap = (32'(pos_r) + 32'd1) >= 32'(wf);
  assign sub_wrap = (32'(sub_r) + 32'd1) >= 32'(eff_f);

  assign wr_addr = col_r;
  assign rd_addr = (32'(idx_r) >= MAX_WIDTH) ? COL_W'(MAX_WIDTH - 1) : idx_r[COL_W-1:0];

  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    reps_nxt      = reps_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    sub_nxt       = sub_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;

    job_valid_nxt = job_valid_r;
    job_kind_nxt  = job_kind_r;
    job_px_nxt    = job_px_r;
    job_left_nxt  = job_left_r;
    job_re_nxt    = job_re_r;
    job_ie_nxt    = job_ie_r;
    job_pad_nxt   = job_pad_r;

    out_valid_nxt = out_valid_r;
    out_px_nxt    = out_px_r;
    out_pad_nxt   = out_pad_r;
    out_re_nxt    = out_re_r;
    out_ie_nxt    = out_ie_r;
    out_drop_nxt  = out_drop_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // one output word per free cycle of the output register
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_px_nxt    = (job_kind_r == JOB_TICK) ? mem_q_r : job_px_r;
      out_pad_nxt   = job_last ? job_pad_r : 2'd0;
      out_re_nxt    = job_last && job_re_r;
      out_ie_nxt    = job_last && job_ie_r;
      out_drop_nxt  = (job_kind_r == JOB_DROP);
      out_last_nxt  = job_last;
      job_left_nxt  = job_left_r - FW'(1);
      if (job_last) begin
        job_valid_nxt = 1'b0;
      end
    end

    if (in_acc) begin
      if (in_tuser == FUNC_PIXEL) begin
        job_valid_nxt = 1'b1;
        job_re_nxt    = 1'b0;
        job_ie_nxt    = 1'b0;
        job_pad_nxt   = 2'd0;
        if (reps_r != '0) begin
          job_kind_nxt = JOB_DROP;
          job_px_nxt   = '0;
          job_left_nxt = FW'(1);
        end else begin
          wr_en        = 1'b1;
          job_kind_nxt = JOB_PIX;
          job_px_nxt   = in_tdata;
          job_left_nxt = eff_f;
          if (col_wrap) begin
            job_re_nxt  = 1'b1;
            job_pad_nxt = row_pad;
            col_nxt     = '0;
            if (eff_f > FW'(1)) begin
              reps_nxt = SUB_W'(eff_f - FW'(1));
              pos_nxt  = '0;
              idx_nxt  = '0;
              sub_nxt  = '0;
            end else begin
              job_ie_nxt = row_wrap;
              row_nxt    = row_inc;
            end
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
        end
      end else if (reps_r != '0) begin
        rd_en         = 1'b1;
        job_valid_nxt = 1'b1;
        job_kind_nxt  = JOB_TICK;
        job_left_nxt  = FW'(1);
        job_re_nxt    = 1'b0;
        job_ie_nxt    = 1'b0;
        job_pad_nxt   = 2'd0;
        if (pos_wrap) begin
          job_re_nxt  = 1'b1;
          job_pad_nxt = row_pad;
          pos_nxt     = '0;
          idx_nxt     = '0;
          sub_nxt     = '0;
          reps_nxt    = reps_r - SUB_W'(1);
          if (reps_r == SUB_W'(1)) begin
            job_ie_nxt = row_wrap;
            row_nxt    = row_inc;
          end
        end else begin
          pos_nxt = pos_r + POS_W'(1);
          if (sub_wrap) begin
            sub_nxt = '0;
            idx_nxt = idx_r + POS_W'(1);
          end else begin
            sub_nxt = sub_r + SUB_W'(1);
          end
        end
      end
    end
  end

  // restoring division step: replay column = position / factor
  assign div_trial   = {div_rem_r, div_q_r[POS_W-1]};
  assign div_ge      = div_trial >= {1'b0, eff_f};
  assign div_rem_nxt = div_ge ? FW'(div_trial - {1'b0, eff_f}) : FW'(div_trial);
  assign div_q_nxt   = POS_W'({div_q_r, div_ge});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      reps_r      <= '0;
      pos_r       <= '0;
      idx_r       <= '0;
      sub_r       <= '0;
      div_busy_r  <= 1'b0;
      div_cnt_r   <= '0;
      job_valid_r <= 1'b0;
      job_kind_r  <= JOB_PIX;
      job_left_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      reps_r      <= reps_nxt;
      pos_r       <= pos_nxt;
      job_valid_r <= job_valid_nxt;
      job_kind_r  <= job_kind_nxt;
      job_left_r  <= job_left_nxt;
      out_valid_r <= out_valid_nxt;
      if (div_start) begin
        div_busy_r <= 1'b1;
        div_cnt_r  <= '0;
        idx_r      <= idx_nxt;
        sub_r      <= sub_nxt;
      end else if (div_busy_r) begin
        div_cnt_r <= div_cnt_r + DCNT_W'(1);
        if (32'(div_cnt_r) == POS_W - 1) begin
          div_busy_r <= 1'b0;
          idx_r      <= div_q_nxt;
          sub_r      <= SUB_W'(div_rem_nxt);
        end
      end else begin
        idx_r <= idx_nxt;
        sub_r <= sub_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_q_r   <= pos_nxt;
      div_rem_r <= '0;
    end else if (div_busy_r) begin
      div_q_r   <= div_q_nxt;
      div_rem_r <= div_rem_nxt;
    end
    job_px_r  <= job_px_nxt;
    job_re_r  <= job_re_nxt;
    job_ie_r  <= job_ie_nxt;
    job_pad_r <= job_pad_nxt;
    out_px_r  <= out_px_nxt;
    out_pad_r <= out_pad_nxt;
    out_re_r  <= out_re_nxt;
    out_ie_r  <= out_ie_nxt;
    out_drop_r <= out_drop_nxt;
    out_last_r <= out_last_nxt;
  end

  // line store; a replay never reads in the cycle of a write, and the write lands
  // before any later read, so no bypass is needed
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= in_tdata;
    end
    if (rd_en) begin
      mem_q_r <= store_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------- outputs
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_ie_r, out_re_r, out_pad_r, out_px_r};
  assign out_tuser  = out_drop_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy_r |-> !in_tready)
    else $error("input accepted during replay column recompute");

  a_job_has_words: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> (job_left_r != '0))
    else $error("pending job with no words left");

  a_replay_row_start: assert property (@(posedge clk) disable iff (!rst_n)
    (reps_r != '0) |-> (col_r == '0))
    else $error("source column moved during replay");

  a_drop_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_drop_r) |-> (out_last_r && out_px_r == '0 && !out_re_r))
    else $error("malformed dropped word");

  a_sub_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !div_busy_r |-> (32'(sub_r) < 32'(eff_f)))
    else $error("replay sub-position beyond factor");
`endif

endmodule
